[sv/assert_macros.svh]
// Assertion macros for the RTL of the conflating update queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define CUQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Checked on every rising edge, during reset as well.
`define CUQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

[sv/cuq_pkg.sv]
// Shared types and constants of the conflating update queue.
package cuq_pkg;

    localparam int DEF_QUEUE_DEPTH  = 16;
    localparam int DEF_NUM_RECORDS  = 1024;
    localparam int DEF_PAYLOAD_BITS = 32;
    localparam int ID_BITS          = 10;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_POP   = 2'd1,
        CMD_CLOSE = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_QUEUED       = 3'd0,
        ST_CONFLATED    = 3'd1,
        ST_FULL_DROPPED = 3'd2,
        ST_EMPTY        = 3'd3,
        ST_POPPED       = 3'd4,
        ST_CLOSED_FOUND = 3'd5,
        ST_CLOSED_NONE  = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_MARK_RD,
        S_ADD,
        S_MARK_WR,
        S_POP,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SH_RD,
        S_SH_WR,
        S_CLOSE_END
    } t_state;

endpackage

[sv/cuq_mark_store.sv]
// Per-record queued marks: one-bit memory with a clearing pass after reset.
module cuq_mark_store #(
    parameter int NUM_RECORDS = cuq_pkg::DEF_NUM_RECORDS,
    parameter int MW          = $clog2(NUM_RECORDS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [MW-1:0] i_rd_addr,
    output logic          o_rd_data,
    input  logic          i_wr_en,
    input  logic [MW-1:0] i_wr_addr,
    input  logic          i_wr_data,
    output logic          o_clearing
);

    logic          mem [NUM_RECORDS];
    logic          r_rd_data;
    logic          r_clearing;
    logic [MW-1:0] r_ptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_ptr      <= '0;
        end else if (r_clearing) begin
            r_ptr <= r_ptr + MW'(1);
            if (r_ptr == MW'(NUM_RECORDS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // The sweep owns the write port until every mark has been cleared.
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_ptr] <= 1'b0;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

[sv/conflating_update_queue.sv]
// Conflating update queue: a FIFO of update words that keeps one waiting entry per record.
//
// A command word is taken when start is high and busy is low; each add, pop or close answers
// with exactly one result word, shown for one cycle with o_valid high, in the cycle after the
// one that settles its status; command code 3 is taken and answered with nothing. The queue
// lives in a circular buffer memory and the marks in a one-bit memory, both with registered
// reads, so an add or pop does one memory read, then the update. When NUM_RECORDS is
// below 1024 and not a power of two the mark index is reduced by repeated subtraction in
// S_MOD, followed by one more mark memory access, for an add or for a pop or close of a
// record. A close reads and compares each entry examined, then reads and writes each later
// entry moved down one place to close the gap.
// After reset busy stays high while the marks are cleared.
// Results cannot be held off: the receiver must take o_valid words as they come.
`include "assert_macros.svh"

module conflating_update_queue #(
    parameter int QUEUE_DEPTH  = cuq_pkg::DEF_QUEUE_DEPTH,
    parameter int NUM_RECORDS  = cuq_pkg::DEF_NUM_RECORDS,
    parameter int PAYLOAD_BITS = cuq_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_command,
    input  logic                       i_has_record,
    input  logic [cuq_pkg::ID_BITS-1:0] i_record_id,
    input  logic [PAYLOAD_BITS-1:0]    i_payload,
    output logic                       o_valid,
    output logic [2:0]                 o_status,
    output logic                       o_out_has_record,
    output logic [cuq_pkg::ID_BITS-1:0] o_out_record_id,
    output logic [PAYLOAD_BITS-1:0]    o_out_payload
);

    import cuq_pkg::*;

    localparam int AW        = $clog2(QUEUE_DEPTH);
    localparam int CW        = $clog2(QUEUE_DEPTH + 1);
    localparam int MW        = $clog2(NUM_RECORDS);
    localparam int ENTRY_W   = 1 + ID_BITS + PAYLOAD_BITS;
    localparam bit IS_POW2   = (NUM_RECORDS & (NUM_RECORDS - 1)) == 0;
    localparam bit NEED_MOD  = (NUM_RECORDS < (1 << ID_BITS)) && !IS_POW2;
    localparam int MOD_STEPS = $clog2(((1 << ID_BITS) - 1) / NUM_RECORDS + 1);
    localparam int KW        = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

    // Queue memory.
    logic [ENTRY_W-1:0] qmem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] r_qdata;
    logic               q_wr_en;
    logic [AW-1:0]      q_wr_addr;
    logic [ENTRY_W-1:0] q_wr_data;
    logic [AW-1:0]      q_rd_addr;

    // Mark memory ports.
    logic          m_rd_data;
    logic [MW-1:0] m_rd_addr;
    logic          m_wr_en;
    logic [MW-1:0] m_wr_addr;
    logic          m_wr_data;
    logic          w_clearing;

    t_state r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [AW-1:0]           r_head, n_head;
    t_cmd                    r_cmd, n_cmd;
    logic                    r_has, n_has;
    logic [ID_BITS-1:0]      r_id, n_id;
    logic [PAYLOAD_BITS-1:0] r_payload, n_payload;
    logic [ID_BITS-1:0]      r_rem, n_rem;
    logic [KW-1:0]           r_k, n_k;
    logic [CW-1:0]           r_i, n_i;
    logic [CW-1:0]           r_j, n_j;
    logic                    r_found, n_found;

    logic                    r_valid, n_valid;
    t_status                 r_status, n_status;
    logic                    r_out_has, n_out_has;
    logic [ID_BITS-1:0]      r_out_id, n_out_id;
    logic [PAYLOAD_BITS-1:0] r_out_payload, n_out_payload;

    logic                    w_accept;
    logic                    e_has;
    logic [ID_BITS-1:0]      e_id;
    logic [PAYLOAD_BITS-1:0] e_payload;
    logic                    w_match;
    logic [CW-1:0]           w_jn;
    logic [ID_BITS:0]        w_sub;
    logic [AW-1:0]           w_tail;
    logic [AW-1:0]           w_head_inc;
    logic                    w_pop_res;
    logic                    w_add_res;

    function automatic logic [AW-1:0] f_pos(input logic [AW-1:0] head,
                                           input logic [CW-1:0] off);
        logic [AW:0] s;
        s = (AW + 1)'(head) + (AW + 1)'(off);
        if (s >= (AW + 1)'(QUEUE_DEPTH)) begin
            s = s - (AW + 1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    cuq_mark_store #(
        .NUM_RECORDS (NUM_RECORDS),
        .MW          (MW)
    ) u_marks (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (m_rd_addr),
        .o_rd_data  (m_rd_data),
        .i_wr_en    (m_wr_en),
        .i_wr_addr  (m_wr_addr),
        .i_wr_data  (m_wr_data),
        .o_clearing (w_clearing)
    );

    assign busy     = (r_state != S_IDLE) || w_clearing;
    assign w_accept = start && !busy;

    assign e_has     = r_qdata[ENTRY_W-1];
    assign e_id      = r_qdata[PAYLOAD_BITS +: ID_BITS];
    assign e_payload = r_qdata[PAYLOAD_BITS-1:0];
    assign w_match   = (e_has == r_has) && (!r_has || (e_id == r_id));
    assign w_jn      = r_j + CW'(1);
    assign w_sub     = (ID_BITS + 1)'(NUM_RECORDS) << r_k;
    assign w_tail    = f_pos(r_head, r_count);
    assign w_head_inc = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + AW'(1);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_cmd'(i_command))
                        CMD_ADD:   n_state = (NEED_MOD && i_has_record) ? S_MOD : S_ADD;
                        CMD_POP:   n_state = S_POP;
                        CMD_CLOSE: n_state = S_SCAN_RD;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_MOD: begin
                if (r_k == '0) begin
                    n_state = (r_cmd == CMD_ADD) ? S_MARK_RD : S_MARK_WR;
                end
            end
            S_MARK_RD: n_state = S_ADD;
            S_ADD:     n_state = S_IDLE;
            S_MARK_WR: n_state = S_IDLE;
            S_POP: begin
                n_state = (NEED_MOD && (r_count != '0) && e_has) ? S_MOD : S_IDLE;
            end
            S_SCAN_RD:  n_state = (r_i == r_count) ? S_CLOSE_END : S_SCAN_CMP;
            S_SCAN_CMP: n_state = w_match ? S_SH_RD : S_SCAN_RD;
            S_SH_RD:    n_state = (w_jn == r_count) ? S_CLOSE_END : S_SH_WR;
            S_SH_WR:    n_state = S_SH_RD;
            S_CLOSE_END: n_state = (NEED_MOD && r_has) ? S_MOD : S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath, memory controls and result word.
    always_comb begin
        n_count   = r_count;
        n_head    = r_head;
        n_cmd     = r_cmd;
        n_has     = r_has;
        n_id      = r_id;
        n_payload = r_payload;
        n_rem     = r_rem;
        n_k       = KW'(MOD_STEPS - 1);
        n_i       = r_i;
        n_j       = r_j;
        n_found   = r_found;

        q_rd_addr = r_head;
        q_wr_en   = 1'b0;
        q_wr_addr = w_tail;
        q_wr_data = r_qdata;

        m_rd_addr = MW'(r_rem);
        m_wr_en   = 1'b0;
        m_wr_addr = MW'(r_rem);
        m_wr_data = 1'b0;

        n_valid       = 1'b0;
        n_status      = ST_QUEUED;
        n_out_has     = 1'b0;
        n_out_id      = '0;
        n_out_payload = '0;

        case (r_state)
            S_IDLE: begin
                // Read both memories here; pop and a mod-free add use the data next cycle.
                m_rd_addr = MW'(i_record_id);
                if (w_accept) begin
                    n_cmd     = t_cmd'(i_command);
                    n_has     = i_has_record;
                    n_id      = i_record_id;
                    n_payload = i_payload;
                    n_rem     = i_record_id;
                    n_i       = '0;
                    n_found   = 1'b0;
                end
            end
            S_MOD: begin
                n_k = r_k - KW'(1);
                if ({1'b0, r_rem} >= w_sub) begin
                    n_rem = r_rem - w_sub[ID_BITS-1:0];
                end
            end
            S_MARK_RD: begin
                m_rd_addr = MW'(r_rem);
            end
            S_ADD: begin
                n_valid = 1'b1;
                if (r_has && m_rd_data) begin
                    n_status = ST_CONFLATED;
                end else if (r_count == CW'(QUEUE_DEPTH)) begin
                    n_status = ST_FULL_DROPPED;
                end else begin
                    n_status  = ST_QUEUED;
                    q_wr_en   = 1'b1;
                    q_wr_addr = w_tail;
                    q_wr_data = {r_has, (r_has ? r_id : ID_BITS'(0)), r_payload};
                    n_count   = r_count + CW'(1);
                    m_wr_en   = r_has;
                    m_wr_addr = NEED_MOD ? MW'(r_rem) : MW'(r_id);
                    m_wr_data = 1'b1;
                end
            end
            S_MARK_WR: begin
                m_wr_en   = 1'b1;
                m_wr_addr = MW'(r_rem);
                m_wr_data = 1'b0;
            end
            S_POP: begin
                n_valid = 1'b1;
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_status      = ST_POPPED;
                    n_out_has     = e_has;
                    n_out_id      = e_id;
                    n_out_payload = e_payload;
                    n_head        = w_head_inc;
                    n_count       = r_count - CW'(1);
                    n_rem         = e_id;
                    m_wr_en       = e_has && !NEED_MOD;
                    m_wr_addr     = MW'(e_id);
                    m_wr_data     = 1'b0;
                end
            end
            S_SCAN_RD: begin
                q_rd_addr = f_pos(r_head, r_i);
            end
            S_SCAN_CMP: begin
                if (w_match) begin
                    n_found = 1'b1;
                    n_j     = r_i;
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            S_SH_RD: begin
                // Later entries move down one place to close the gap.
                q_rd_addr = f_pos(r_head, w_jn);
                if (w_jn == r_count) begin
                    n_count = r_count - CW'(1);
                end
            end
            S_SH_WR: begin
                q_wr_en   = 1'b1;
                q_wr_addr = f_pos(r_head, r_j);
                q_wr_data = r_qdata;
                n_j       = w_jn;
            end
            S_CLOSE_END: begin
                n_valid   = 1'b1;
                n_status  = r_found ? ST_CLOSED_FOUND : ST_CLOSED_NONE;
                m_wr_en   = r_has && !NEED_MOD;
                m_wr_addr = MW'(r_id);
                m_wr_data = 1'b0;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (q_wr_en) begin
            qmem[q_wr_addr] <= q_wr_data;
        end
        r_qdata <= qmem[q_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_valid <= 1'b0;
            r_found <= 1'b0;
            r_k     <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_valid <= n_valid;
            r_found <= n_found;
            r_k     <= n_k;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_has         <= n_has;
        r_id          <= n_id;
        r_payload     <= n_payload;
        r_rem         <= n_rem;
        r_status      <= n_status;
        r_out_has     <= n_out_has;
        r_out_id      <= n_out_id;
        r_out_payload <= n_out_payload;
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_out_has_record = r_out_has;
    assign o_out_record_id  = r_out_id;
    assign o_out_payload    = r_out_payload;

    assign w_pop_res = o_valid && (r_status == ST_POPPED);
    assign w_add_res = o_valid && (r_status == ST_QUEUED);

    `CUQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(QUEUE_DEPTH))
    `CUQ_ASSERT(a_clear_busy, i_clk, i_rst_n, w_clearing |-> busy)
    `CUQ_ASSERT(a_pop_count, i_clk, i_rst_n, w_pop_res |-> (r_count + CW'(1) == $past(r_count)))
    `CUQ_ASSERT(a_add_count, i_clk, i_rst_n, w_add_res |-> (r_count == $past(r_count) + CW'(1)))
    `CUQ_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_valid)

endmodule
